// ===== hdl/lrm_pkg.sv =====
// ============================================================================
// lrm_pkg
// Shared types and constants for the linkage distance row merge block.
// ============================================================================
package lrm_pkg;

  // Field widths
  localparam int unsigned DIST_W   = 24;             // unsigned Q16.8 distance
  localparam int unsigned IDX_IN_W = 6;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned WSUM_W   = CNT_W + 1;      // count_a + count_b
  localparam int unsigned PROD_W   = DIST_W + CNT_W; // distance * count
  localparam int unsigned DVD_W    = PROD_W + 1;     // sum of two products
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned STAT_W   = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = CFG_IDX_W'(1);

  // Divider: quotient bits retired per cycle
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_CYCLES = DIST_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  // Actions
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MERGE = 2'd2;

  // Linkage modes
  localparam logic [MODE_W-1:0] MODE_AVG    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN    = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd2;

  // Input beat
  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [IDX_IN_W-1:0] row_index;
    logic [IDX_IN_W-1:0] col_index;
    logic [DIST_W-1:0]   entry_value;
    logic [CNT_W-1:0]    count_a;
    logic [CNT_W-1:0]    count_b;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [DIST_W-1:0] read_value;
    logic [STAT_W-1:0] status;
  } out_result_t;

  // Divider request
  typedef struct packed {
    logic [DVD_W-1:0]  dividend;
    logic [WSUM_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== hdl/linkage_distance_row_merge_core.sv =====
// ============================================================================
// linkage_distance_row_merge_core
// Cluster distance matrix with host write/read and linkage row merge.
// ============================================================================
// A write or an error gets its result strobe from the dispatch state, a read from S_RDWAIT.
// A merge forms the new row column by column (single/complete: min/max; average:
// weighted mean through the divider), then writes row and column a back, all
// through the one port of the matrix memory.
// One item at a time: busy stays high until the result strobe; no stall.
// Reset: mode average, size 64; matrix contents undefined until written.
module linkage_distance_row_merge_core #(
  parameter int unsigned MAX_CLUSTERS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  lrm_pkg::in_item_t                in_item,
  // result channel
  output logic                             out_valid,
  output lrm_pkg::out_result_t             out_result,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lrm_pkg::*;

  localparam int unsigned IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned AW    = 2 * IDX_W;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned ROWS  = 1 << IDX_W;

  // State codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_RDWAIT = 4'd2;
  localparam logic [3:0] S_M_RDA  = 4'd3;
  localparam logic [3:0] S_M_RDB  = 4'd4;
  localparam logic [3:0] S_M_CAP  = 4'd5;
  localparam logic [3:0] S_M_SUM  = 4'd6;
  localparam logic [3:0] S_M_DIV  = 4'd7;
  localparam logic [3:0] S_W_RD   = 4'd8;
  localparam logic [3:0] S_W_ROW  = 4'd9;
  localparam logic [3:0] S_W_COL  = 4'd10;

  logic [3:0]         state_r, state_nxt;
  in_item_t           item_r;
  logic [MODE_W-1:0]  mode_r;
  logic [SIZE_W-1:0]  size_r;
  logic [IDX_W-1:0]   col_r, col_nxt;
  logic [DIST_W-1:0]  da_r, da_nxt;
  logic [PROD_W-1:0]  prod_a_r, prod_a_nxt, prod_b_r, prod_b_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_result_t        out_result_r, out_result_nxt;

  // Matrix memory port
  logic [DIST_W-1:0]  dist_mem [DEPTH];
  logic               st_we;
  logic [AW-1:0]      st_addr;
  logic [DIST_W-1:0]  st_wdata;
  logic [DIST_W-1:0]  st_rdata_r;

  // New row buffer port
  logic [DIST_W-1:0]  row_mem [ROWS];
  logic               buf_we;
  logic [IDX_W-1:0]   buf_addr;
  logic [DIST_W-1:0]  buf_wdata;
  logic [DIST_W-1:0]  buf_rdata_r;

  // Divider
  logic               div_start;
  div_req_t           div_req;
  logic               div_done;
  logic [DIST_W-1:0]  div_quo;

  // Derived item values
  logic [SIZE_W-1:0]  n_eff;
  logic [IDX_W-1:0]   a_idx, b_idx;
  logic [WSUM_W-1:0]  wsum;
  logic               in_range;
  logic               last_col;
  logic [DIST_W-1:0]  db;

  // Effective size and index checks
  assign n_eff    = (32'(size_r) < MAX_CLUSTERS) ? size_r : SIZE_W'(MAX_CLUSTERS);
  assign a_idx    = IDX_W'(item_r.row_index);
  assign b_idx    = IDX_W'(item_r.col_index);
  assign wsum     = WSUM_W'(item_r.count_a) + WSUM_W'(item_r.count_b);
  assign in_range = (SIZE_W'(item_r.row_index) < n_eff) &&
                    (SIZE_W'(item_r.col_index) < n_eff);
  assign last_col = ((32'(col_r) + 32'd1) == 32'(n_eff));
  assign db       = st_rdata_r;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_result = out_result_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    da_nxt         = da_r;
    prod_a_nxt     = prod_a_r;
    prod_b_nxt     = prod_b_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    st_we          = 1'b0;
    st_addr        = {a_idx, col_r};
    st_wdata       = buf_rdata_r;
    buf_we         = 1'b0;
    buf_addr       = col_r;
    buf_wdata      = div_quo;
    div_start      = 1'b0;
    div_req.dividend = DVD_W'(prod_a_r) + DVD_W'(prod_b_r);
    div_req.divisor  = wsum;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        out_result_nxt.read_value = '0;
        out_result_nxt.status     = STAT_OK;
        col_nxt                   = '0;
        if (item_r.action != ACT_WRITE && item_r.action != ACT_READ &&
            item_r.action != ACT_MERGE) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (!in_range) begin
          out_result_nxt.status = STAT_RANGE;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end else if (item_r.action == ACT_WRITE) begin
          st_we         = 1'b1;
          st_addr       = {a_idx, b_idx};
          st_wdata      = item_r.entry_value;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (item_r.action == ACT_READ) begin
          st_addr   = {a_idx, b_idx};
          state_nxt = S_RDWAIT;
        end else if (mode_r != MODE_AVG && mode_r != MODE_MAX && mode_r != MODE_MIN) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (mode_r == MODE_AVG && wsum == '0) begin
          out_result_nxt.status = STAT_ZERO;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end else begin
          state_nxt = S_M_RDA;
        end
      end

      S_RDWAIT: begin
        out_result_nxt.read_value = st_rdata_r;
        out_result_nxt.status     = STAT_OK;
        out_valid_nxt             = 1'b1;
        state_nxt                 = S_IDLE;
      end

      // read (a,i)
      S_M_RDA: begin
        st_addr   = {a_idx, col_r};
        state_nxt = S_M_RDB;
      end

      // take (a,i), read (b,i)
      S_M_RDB: begin
        da_nxt    = st_rdata_r;
        st_addr   = {b_idx, col_r};
        state_nxt = S_M_CAP;
      end

      // (b,i) is here: pick min/max, or form the weighted products
      S_M_CAP: begin
        if (mode_r == MODE_AVG) begin
          prod_a_nxt = PROD_W'(da_r) * PROD_W'(item_r.count_a);
          prod_b_nxt = PROD_W'(db) * PROD_W'(item_r.count_b);
          state_nxt  = S_M_SUM;
        end else begin
          buf_we = 1'b1;
          if (mode_r == MODE_MAX) begin
            buf_wdata = (da_r > db) ? da_r : db;
          end else begin
            buf_wdata = (da_r < db) ? da_r : db;
          end
          if (last_col) begin
            col_nxt   = '0;
            state_nxt = S_W_RD;
          end else begin
            col_nxt   = col_r + 1'b1;
            state_nxt = S_M_RDA;
          end
        end
      end

      S_M_SUM: begin
        div_start = 1'b1;
        state_nxt = S_M_DIV;
      end

      S_M_DIV: begin
        if (div_done) begin
          buf_we    = 1'b1;
          buf_wdata = div_quo;
          if (last_col) begin
            col_nxt   = '0;
            state_nxt = S_W_RD;
          end else begin
            col_nxt   = col_r + 1'b1;
            state_nxt = S_M_RDA;
          end
        end
      end

      // write-back: for each column i, read the buffer, write (a,i), then write (i,a)
      S_W_RD: begin
        buf_addr  = col_r;
        state_nxt = S_W_ROW;
      end

      S_W_ROW: begin
        st_we     = 1'b1;
        st_addr   = {a_idx, col_r};
        st_wdata  = buf_rdata_r;
        state_nxt = S_W_COL;
      end

      S_W_COL: begin
        st_we    = 1'b1;
        st_addr  = {col_r, a_idx};
        st_wdata = buf_rdata_r;
        if (last_col) begin
          out_result_nxt.read_value = '0;
          out_result_nxt.status     = STAT_OK;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end else begin
          col_nxt   = col_r + 1'b1;
          state_nxt = S_W_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_AVG;
      size_r      <= SIZE_W'(64);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) begin
          mode_r <= cfg_data[MODE_W-1:0];
        end else if (cfg_index == REG_SIZE) begin
          size_r <= cfg_data[SIZE_W-1:0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      item_r <= in_item;
    end
    col_r        <= col_nxt;
    da_r         <= da_nxt;
    prod_a_r     <= prod_a_nxt;
    prod_b_r     <= prod_b_nxt;
    out_result_r <= out_result_nxt;
  end

  // Matrix memory, single port, registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      dist_mem[st_addr] <= st_wdata;
    end
    st_rdata_r <= dist_mem[st_addr];
  end

  // New row buffer, registered read
  always_ff @(posedge clk) begin
    if (buf_we) begin
      row_mem[buf_addr] <= buf_wdata;
    end
    buf_rdata_r <= row_mem[buf_addr];
  end

  lrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Checks
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while still working");

  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> ((state_r == S_DISP && item_r.action == ACT_WRITE && in_range) ||
               state_r == S_W_ROW || state_r == S_W_COL))
    else $error("matrix written outside write or write-back");

  a_buf_write: assert property (@(posedge clk) disable iff (!rst_n)
    buf_we |-> ((32'(col_r) < 32'(n_eff)) &&
                (state_r == S_M_CAP || state_r == S_M_DIV)))
    else $error("row buffer written out of range");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (mode_r == MODE_AVG && wsum != '0))
    else $error("divider started outside average merge");

endmodule

// ===== hdl/lrm_div.sv =====
// ============================================================================
// lrm_div
// Iterative restoring divider for the weighted mean, two quotient bits a cycle.
// ============================================================================
module lrm_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  lrm_pkg::div_req_t        req,
  output logic                     done,
  output logic [lrm_pkg::DIST_W-1:0] quotient
);
  import lrm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WSUM_W-1:0]    divisor_r;
  logic [WSUM_W-1:0]    rem_r, rem_nxt;
  logic [DIST_W-1:0]    quo_r, quo_nxt;
  logic [WSUM_W:0]      trial;
  logic                 ge;

  // Two restoring steps; remainder stays below the divisor, so 17 bits do
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    ge      = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_nxt, quo_nxt[DIST_W-1]};
      ge    = (trial >= {1'b0, divisor_r});
      if (ge) begin
        rem_nxt = WSUM_W'(trial - {1'b0, divisor_r});
      end else begin
        rem_nxt = trial[WSUM_W-1:0];
      end
      quo_nxt = {quo_nxt[DIST_W-2:0], ge};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_CYCLES);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; the quotient is known to fit 24 bits, so start from the top part
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= req.dividend[DVD_W-1:DIST_W];
      quo_r     <= req.dividend[DIST_W-1:0];
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  // Checks
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == DIV_CNT_W'(1)) |=> (done_r && !busy_r))
    else $error("divider did not finish on last step");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < divisor_r))
    else $error("divider remainder not below divisor");

endmodule
